>>> rtl/core/hfv_pkg.sv
package hfv_pkg;

  // Field widths
  localparam int DATA_W      = 8;
  localparam int FRAME_LEN_W = 21;
  localparam int HOST_LEN_W  = 13;
  localparam int VERSION_W   = 32;
  localparam int INTENT_W    = 2;
  localparam int VERDICT_W   = 2;
  localparam int CONSUMED_W  = 22;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_LEN_MAX        = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOST_LEN_MAX         = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TRANSFER_MIN_VERSION = 2'd2;

  localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_MAX_RST        = 21'd786;
  localparam logic [HOST_LEN_W-1:0]  HOST_LEN_MAX_RST         = 13'd765;
  localparam logic [VERSION_W-1:0]   TRANSFER_MIN_VERSION_RST = 32'd766;

  // Reported verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_MATCH     = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_NO_MATCH  = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_NEED_MORE = 2'd2;

  // Parameter defaults
  localparam int LENGTH_PREFIX_BYTES_DEF = 3;
  localparam int VARINT_MAX_BYTES_DEF    = 5;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;
  } hfv_byte_t;

  typedef struct packed {
    logic [VERDICT_W-1:0]        verdict;
    logic signed [VERSION_W-1:0] client_version;
    logic [INTENT_W-1:0]         intention;
    logic [CONSUMED_W-1:0]       bytes_consumed;
  } hfv_result_t;

endpackage

>>> rtl/core/hfv_if.sv
// Segment byte stream
interface hfv_byte_if;
  logic                             valid;
  logic                             ready;
  logic [hfv_pkg::DATA_W-1:0]       data_byte;
  logic                             last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// Verdict stream, one transfer per segment
interface hfv_result_if;
  logic                                    valid;
  logic                                    ready;
  logic [hfv_pkg::VERDICT_W-1:0]           verdict;
  logic signed [hfv_pkg::VERSION_W-1:0]    client_version;
  logic [hfv_pkg::INTENT_W-1:0]            intention;
  logic [hfv_pkg::CONSUMED_W-1:0]          bytes_consumed;

  modport source (output valid, output verdict, output client_version,
                  output intention, output bytes_consumed, input ready);
  modport sink (input valid, input verdict, input client_version,
                input intention, input bytes_consumed, output ready);
endinterface

>>> rtl/core/handshake_frame_validator.sv
// Handshake frame validator.
// segment: one payload byte per transfer, last_byte set on the segment's
//   final byte. The bytes are checked against a length-prefixed handshake
//   frame (varint length, id 0, varint version, host string, port, intention).
// result: one transfer per segment, sent for the last byte: verdict
//   (match / no match / need more data), version, intention and the number
//   of bytes the frame covers; the last three are zero unless it matched.
// cfg_write/cfg_index/cfg_data: write frame_len_max (0), host_len_max (1)
//   and transfer_min_version (2); write only while no segment is in flight.
// Throughput: one byte per cycle unless a final byte waits on a full
//   result register. Each byte is held in the input register and parsed
//   by the next-state logic, and the segment's result is then registered.
// Stall: non-final bytes keep flowing while a result waits; a final byte
//   holds in the input register until the result register is free, and
//   segment.ready drops only then.
// Reset (rst, synchronous): configuration registers return to their
//   defaults, parse state clears and both stages empty.
module handshake_frame_validator #(
  parameter int LENGTH_PREFIX_BYTES = hfv_pkg::LENGTH_PREFIX_BYTES_DEF,
  parameter int VARINT_MAX_BYTES    = hfv_pkg::VARINT_MAX_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  hfv_byte_if.sink                        segment,
  hfv_result_if.source                    result,
  input  logic                            cfg_write,
  input  logic [hfv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hfv_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                 held_valid;
  hfv_pkg::hfv_byte_t   held;
  logic                 take;
  logic                 res_load;
  logic                 out_room;
  hfv_pkg::hfv_result_t res;

  hfv_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .segment    (segment),
    .take       (take),
    .held_valid (held_valid),
    .held       (held)
  );

  hfv_parser #(
    .LENGTH_PREFIX_BYTES (LENGTH_PREFIX_BYTES),
    .VARINT_MAX_BYTES    (VARINT_MAX_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .held_valid (held_valid),
    .held       (held),
    .out_room   (out_room),
    .take       (take),
    .res_load   (res_load),
    .res        (res)
  );

  hfv_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .res_load (res_load),
    .res      (res),
    .out_room (out_room),
    .result   (result)
  );

  // A result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> out_room)
    else $error("result register overwritten");

  // A held byte that is not parsed stays held
  a_hold_byte: assert property (@(posedge clk) disable iff (rst)
    (held_valid && !take) |=> held_valid)
    else $error("held byte lost");

  // Anything but a match reports zero fields
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.verdict != hfv_pkg::VERDICT_MATCH)) |->
      ((result.client_version == '0) && (result.intention == '0) &&
       (result.bytes_consumed == '0)))
    else $error("non-match result carries data");

  // Shortest matching frame: one prefix byte and six body bytes
  a_match_size: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.verdict == hfv_pkg::VERDICT_MATCH)) |->
      (result.bytes_consumed >= hfv_pkg::CONSUMED_W'(7)))
    else $error("match with impossible size");

endmodule

>>> rtl/core/hfv_in_stage.sv
module hfv_in_stage (
  input  logic               clk,
  input  logic               rst,
  hfv_byte_if.sink           segment,
  input  logic               take,
  output logic               held_valid,
  output hfv_pkg::hfv_byte_t held
);

  // Free, or emptied by the parser this cycle
  assign segment.ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (segment.valid && segment.ready) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (segment.valid && segment.ready) begin
      held.data_byte <= segment.data_byte;
      held.last_byte <= segment.last_byte;
    end
  end

endmodule

>>> rtl/core/hfv_parser.sv
module hfv_parser #(
  parameter int LENGTH_PREFIX_BYTES = hfv_pkg::LENGTH_PREFIX_BYTES_DEF,
  parameter int VARINT_MAX_BYTES    = hfv_pkg::VARINT_MAX_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [hfv_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [hfv_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               held_valid,
  input  hfv_pkg::hfv_byte_t                 held,
  input  logic                               out_room,
  output logic                               take,
  output logic                               res_load,
  output hfv_pkg::hfv_result_t               res
);

  localparam int MaxCount = (LENGTH_PREFIX_BYTES > VARINT_MAX_BYTES) ?
                            LENGTH_PREFIX_BYTES : VARINT_MAX_BYTES;
  localparam int CntW     = $clog2(MaxCount + 1);
  localparam int PlW      = $clog2(LENGTH_PREFIX_BYTES + 1);
  localparam int AccW     = hfv_pkg::VERSION_W;

  // Parse phases
  localparam logic [2:0] PH_PREFIX  = 3'd0;
  localparam logic [2:0] PH_ID      = 3'd1;
  localparam logic [2:0] PH_VERSION = 3'd2;
  localparam logic [2:0] PH_HOSTLEN = 3'd3;
  localparam logic [2:0] PH_HOST    = 3'd4;
  localparam logic [2:0] PH_PORT    = 3'd5;
  localparam logic [2:0] PH_INTENT  = 3'd6;
  localparam logic [2:0] PH_TRAIL   = 3'd7;

  // Decision state
  localparam logic [1:0] VF_NONE    = 2'd0;
  localparam logic [1:0] VF_MATCH   = 2'd1;
  localparam logic [1:0] VF_NOMATCH = 2'd2;

  // Configuration registers
  logic [hfv_pkg::FRAME_LEN_W-1:0] frame_len_max;
  logic [hfv_pkg::HOST_LEN_W-1:0]  host_len_max;
  logic [hfv_pkg::VERSION_W-1:0]   transfer_min_version;

  // Parse state
  logic [2:0]                      phase, phase_next;
  logic [AccW-1:0]                 acc, acc_next;
  logic [CntW-1:0]                 cnt, cnt_next;
  logic [hfv_pkg::FRAME_LEN_W-1:0] frame_len, frame_len_next;
  logic [PlW-1:0]                  prefix_len, prefix_len_next;
  logic [hfv_pkg::FRAME_LEN_W-1:0] body_count, body_count_next;
  logic [hfv_pkg::HOST_LEN_W-1:0]  skip_left, skip_left_next;
  logic [hfv_pkg::VERSION_W-1:0]   version, version_next;
  logic [hfv_pkg::INTENT_W-1:0]    intent, intent_next;
  logic                            body_err, body_err_next;
  logic [1:0]                      vfix, vfix_next;

  logic [hfv_pkg::DATA_W-1:0]      b;
  logic [AccW-1:0]                 acc_add;
  logic [CntW-1:0]                 cnt_inc;
  logic [hfv_pkg::HOST_LEN_W-1:0]  skip_dec;
  logic                            intent_ok;

  // Byte leaves the input register unless it closes the segment and the
  // output register is still occupied
  assign take     = held_valid && (!held.last_byte || out_room);
  assign res_load = take && held.last_byte;
  assign b        = held.data_byte;

  // Merge the low seven bits of the byte at the current varint position
  always_comb begin
    acc_add = acc;
    for (int k = 0; k < 5; k++) begin
      if (int'(cnt) == k) begin
        acc_add = acc | (AccW'(b[6:0]) << (7 * k));
      end
    end
  end

  assign cnt_inc   = cnt + CntW'(1);
  assign skip_dec  = skip_left - hfv_pkg::HOST_LEN_W'(1);
  assign intent_ok = (b == 8'd1) || (b == 8'd2) ||
                     ((b == 8'd3) && ($signed(version) >= $signed(transfer_min_version)));

  // Per-byte state update
  always_comb begin
    phase_next      = phase;
    acc_next        = acc;
    cnt_next        = cnt;
    frame_len_next  = frame_len;
    prefix_len_next = prefix_len;
    body_count_next = body_count;
    skip_left_next  = skip_left;
    version_next    = version;
    intent_next     = intent;
    body_err_next   = body_err;
    vfix_next       = vfix;

    if (vfix != VF_NONE) begin
      // decided: ignore until segment end
    end else if (phase == PH_PREFIX) begin
      acc_next = acc_add;
      cnt_next = cnt_inc;
      if (!b[7]) begin
        if ((acc_add == '0) || acc_add[AccW-1] ||
            (acc_add > AccW'(frame_len_max))) begin
          vfix_next = VF_NOMATCH;
        end else begin
          frame_len_next  = acc_add[hfv_pkg::FRAME_LEN_W-1:0];
          prefix_len_next = PlW'(cnt_inc);
          body_count_next = '0;
          phase_next      = PH_ID;
          acc_next        = '0;
          cnt_next        = '0;
        end
      end else if (int'(cnt_inc) >= LENGTH_PREFIX_BYTES) begin
        vfix_next = VF_NOMATCH;
      end
    end else begin
      // Body byte; once a fault is recorded only the count moves on
      if (!body_err) begin
        unique case (phase)
          PH_ID: begin
            if (b != '0) body_err_next = 1'b1;
            phase_next = PH_VERSION;
            acc_next   = '0;
            cnt_next   = '0;
          end
          PH_VERSION, PH_HOSTLEN: begin
            acc_next = acc_add;
            cnt_next = cnt_inc;
            if (!b[7]) begin
              if (phase == PH_VERSION) begin
                version_next = acc_add;
                phase_next   = PH_HOSTLEN;
              end else if (acc_add[AccW-1] || (acc_add > AccW'(host_len_max))) begin
                body_err_next = 1'b1;
              end else if (acc_add == '0) begin
                phase_next     = PH_PORT;
                skip_left_next = hfv_pkg::HOST_LEN_W'(2);
              end else begin
                phase_next     = PH_HOST;
                skip_left_next = acc_add[hfv_pkg::HOST_LEN_W-1:0];
              end
              acc_next = '0;
              cnt_next = '0;
            end else if (int'(cnt_inc) >= VARINT_MAX_BYTES) begin
              body_err_next = 1'b1;
            end
          end
          PH_HOST: begin
            skip_left_next = skip_dec;
            if (skip_dec == '0) begin
              phase_next     = PH_PORT;
              skip_left_next = hfv_pkg::HOST_LEN_W'(2);
            end
          end
          PH_PORT: begin
            skip_left_next = skip_dec;
            if (skip_dec == '0) phase_next = PH_INTENT;
          end
          PH_INTENT: begin
            if (intent_ok) begin
              intent_next = b[hfv_pkg::INTENT_W-1:0];
              phase_next  = PH_TRAIL;
            end else begin
              body_err_next = 1'b1;
            end
          end
          default: begin
            // trailing byte inside the frame
            body_err_next = 1'b1;
          end
        endcase
      end
      body_count_next = body_count + hfv_pkg::FRAME_LEN_W'(1);
      // Frame complete: settle the verdict
      if (body_count_next >= frame_len) begin
        if (phase_next != PH_TRAIL) body_err_next = 1'b1;
        vfix_next = body_err_next ? VF_NOMATCH : VF_MATCH;
      end
    end
  end

  // Result for the segment's last byte
  always_comb begin
    res.verdict        = hfv_pkg::VERDICT_NEED_MORE;
    res.client_version = '0;
    res.intention      = '0;
    res.bytes_consumed = '0;
    unique case (vfix_next)
      VF_MATCH: begin
        res.verdict        = hfv_pkg::VERDICT_MATCH;
        res.client_version = $signed(version_next);
        res.intention      = intent_next;
        res.bytes_consumed = hfv_pkg::CONSUMED_W'(prefix_len_next) +
                             hfv_pkg::CONSUMED_W'(frame_len_next);
      end
      VF_NOMATCH: res.verdict = hfv_pkg::VERDICT_NO_MATCH;
      default:    res.verdict = hfv_pkg::VERDICT_NEED_MORE;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_len_max        <= hfv_pkg::FRAME_LEN_MAX_RST;
      host_len_max         <= hfv_pkg::HOST_LEN_MAX_RST;
      transfer_min_version <= hfv_pkg::TRANSFER_MIN_VERSION_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        hfv_pkg::CFG_FRAME_LEN_MAX:
          frame_len_max <= cfg_data[hfv_pkg::FRAME_LEN_W-1:0];
        hfv_pkg::CFG_HOST_LEN_MAX:
          host_len_max <= cfg_data[hfv_pkg::HOST_LEN_W-1:0];
        hfv_pkg::CFG_TRANSFER_MIN_VERSION:
          transfer_min_version <= cfg_data[hfv_pkg::VERSION_W-1:0];
        default: begin
          // unused index
        end
      endcase
    end
  end

  // Parse state; cleared at segment end
  always_ff @(posedge clk) begin
    if (rst || res_load) begin
      phase      <= PH_PREFIX;
      acc        <= '0;
      cnt        <= '0;
      frame_len  <= '0;
      prefix_len <= '0;
      body_count <= '0;
      skip_left  <= '0;
      version    <= '0;
      intent     <= '0;
      body_err   <= 1'b0;
      vfix       <= VF_NONE;
    end else if (take) begin
      phase      <= phase_next;
      acc        <= acc_next;
      cnt        <= cnt_next;
      frame_len  <= frame_len_next;
      prefix_len <= prefix_len_next;
      body_count <= body_count_next;
      skip_left  <= skip_left_next;
      version    <= version_next;
      intent     <= intent_next;
      body_err   <= body_err_next;
      vfix       <= vfix_next;
    end
  end

endmodule

>>> rtl/core/hfv_out_stage.sv
module hfv_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 res_load,
  input  hfv_pkg::hfv_result_t res,
  output logic                 out_room,
  hfv_result_if.source         result
);

  logic                 valid;
  hfv_pkg::hfv_result_t payload;

  assign out_room = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res_load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) payload <= res;
  end

  assign result.valid          = valid;
  assign result.verdict        = payload.verdict;
  assign result.client_version = payload.client_version;
  assign result.intention      = payload.intention;
  assign result.bytes_consumed = payload.bytes_consumed;

endmodule
